[hdl/fdt_pkg.sv]
// Package for the flow data-term weight pipeline: fixed-point types, register
// indexes, unit latencies and the saturating helpers used by the top level.
// No dependencies.
package fdt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_BITS     = 48;
  localparam int MUL_LAT       = 4;
  localparam int SQRT_LAT      = SQRT_BITS + 1;

  localparam logic [7:0] REG_DELTA = 8'd0;
  localparam logic [7:0] REG_GAMMA = 8'd1;

  typedef logic signed [63:0] fix_t;
  typedef logic signed [31:0] word_t;

  localparam fix_t SATW = 64'sh7FFF_FFFF_FFFF_FFFF;

  // Latency of one divider: operand setup, one stage per dividend bit, output.
  function automatic int div_lat(int frac);
    div_lat = frac + 66;
  endfunction

  // Latency from an input transfer to its result strobe.
  function automatic int pipe_lat(int frac);
    pipe_lat = 4 * MUL_LAT + 3 * div_lat(frac) + SQRT_LAT + 4;
  endfunction

  // Sum clamped to the symmetric range +-(2^63-1).
  function automatic fix_t sadd(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SATW)) sadd = SATW;
    else if (s < -65'(SATW)) sadd = -SATW;
    else sadd = s[63:0];
  endfunction

  // Clamp to the signed 32-bit output range.
  function automatic word_t sat32(fix_t v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

[hdl/fdt_delay.sv]
// Fixed-depth shift register used to align operands and valid bits.
// Depends on nothing.
module fdt_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  // Shift one place per clock; reset clears every tap.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) sr[k] <= '0;
    end else begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) sr[k] <= sr[k-1];
    end
  end

  assign q = sr[DEPTH-1];

endmodule

[hdl/fdt_mul.sv]
// Pipelined signed fixed-point multiplier, round to nearest on the magnitude,
// saturating to +-(2^63-1). Uses fdt_pkg.
module fdt_mul import fdt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  fix_t a,
  input  fix_t b,
  output fix_t p
);

  localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

  logic         neg1, neg2, neg3;
  logic [63:0]  ma, mb;
  logic [63:0]  pp00, pp01, pp10, pp11;
  logic [127:0] prod, rnd;
  fix_t         mg;

  // Rounding, scaling and saturation of the full product.
  always_comb begin
    rnd = prod + HALF;
    if ((|rnd[127:63+FRAC_BITS]) != 1'b0) mg = SATW;
    else mg = {1'b0, rnd[62+FRAC_BITS:FRAC_BITS]};
  end

  // Magnitudes, 32x32 partial products, their sum, then the signed result.
  always_ff @(posedge clk) begin
    neg1 <= a[63] ^ b[63];
    ma   <= a[63] ? (64'd0 - a) : a;
    mb   <= b[63] ? (64'd0 - b) : b;
    neg2 <= neg1;
    pp00 <= ma[31:0] * mb[31:0];
    pp01 <= ma[31:0] * mb[63:32];
    pp10 <= ma[63:32] * mb[31:0];
    pp11 <= ma[63:32] * mb[63:32];
    neg3 <= neg2;
    prod <= {64'd0, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0} + {pp11, 64'd0};
    p    <= neg3 ? -mg : mg;
  end

endmodule

[hdl/fdt_div.sv]
// Pipelined fixed-point divider, one restoring quotient bit per stage, with
// round to nearest and saturation. Divisor must be positive. Uses fdt_pkg.
module fdt_div import fdt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  fix_t a,
  input  fix_t d,
  output fix_t res
);

  localparam int NB = 64 + FRAC_BITS;

  logic [NB-1:0] num  [NB+1];
  logic [63:0]   rem  [NB+1];
  logic [63:0]   quo  [NB+1];
  logic [63:0]   dsr  [NB+1];
  logic          over [NB+1];
  logic          neg  [NB+1];
  logic [63:0]   ma;
  fix_t          mg;

  assign ma = a[63] ? (64'd0 - a) : a;

  // Scaled dividend with half the divisor added for rounding.
  always_ff @(posedge clk) begin
    num[0]  <= (NB'(ma) << FRAC_BITS) + NB'(d[63:1]);
    rem[0]  <= '0;
    quo[0]  <= '0;
    dsr[0]  <= d;
    over[0] <= 1'b0;
    neg[0]  <= a[63];
  end

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [63:0] r2;
    assign r2 = {rem[i][62:0], num[i][NB-1]};

    // One quotient bit; overflow once a bit reaches the sign position.
    always_ff @(posedge clk) begin
      num[i+1]  <= num[i] << 1;
      dsr[i+1]  <= dsr[i];
      neg[i+1]  <= neg[i];
      over[i+1] <= over[i] | quo[i][63] | quo[i][62];
      if (r2 >= dsr[i]) begin
        rem[i+1] <= r2 - dsr[i];
        quo[i+1] <= {quo[i][62:0], 1'b1};
      end else begin
        rem[i+1] <= r2;
        quo[i+1] <= {quo[i][62:0], 1'b0};
      end
    end
  end

  assign mg = over[NB] ? SATW : fix_t'(quo[NB]);

  // Apply the dividend sign.
  always_ff @(posedge clk) begin
    res <= neg[NB] ? -mg : mg;
  end

endmodule

[hdl/fdt_sqrt.sv]
// Pipelined square root floor(sqrt(x * 2^FRAC_BITS)) for x >= 0, two radicand
// bits per stage. Uses fdt_pkg.
module fdt_sqrt import fdt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  fix_t x,
  output fix_t y
);

  localparam int R  = SQRT_BITS;
  localparam int VW = 2 * R;

  logic [VW-1:0] rad  [R+1];
  logic [R+1:0]  rem  [R+1];
  logic [R-1:0]  root [R+1];

  // Scaled radicand.
  always_ff @(posedge clk) begin
    rad[0]  <= VW'(x[62:0]) << FRAC_BITS;
    rem[0]  <= '0;
    root[0] <= '0;
  end

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic [R+1:0] r2, trial;
    assign r2    = {rem[i][R-1:0], rad[i][VW-1 -: 2]};
    assign trial = {root[i], 2'b01};

    // One root bit per stage.
    always_ff @(posedge clk) begin
      rad[i+1] <= rad[i] << 2;
      if (r2 >= trial) begin
        rem[i+1]  <= r2 - trial;
        root[i+1] <= {root[i][R-2:0], 1'b1};
      end else begin
        rem[i+1]  <= r2;
        root[i+1] <= {root[i][R-2:0], 1'b0};
      end
    end
  end

  assign y = fix_t'(64'(root[R]));

endmodule

[hdl/flow_data_term_weights.sv]
// Top level of the flow data-term weight pipeline: robust brightness and
// gradient weights and their 2x2 system contributions. Uses fdt_pkg and
// fdt_mul, fdt_div, fdt_sqrt, fdt_delay.
//
//  Channel  | Transfer                          | Payload
//  ---------+-----------------------------------+-----------------------------
//  input    | start && !busy at a clock edge    | grad_*, temporal_diff, du,
//           |                                   | dv, valid_req
//  result   | done high for one cycle           | add_a00..add_b1
//  config   | cfg_valid && cfg_ready            | cfg_index, cfg_data
//
// One pixel enters every cycle; busy is never raised.
// Latency is set by the chain of three pipelined dividers, the square root and
// four multipliers.
// Reset (rst, synchronous) clears the valid lines and loads the default weights.
// The receiver cannot stall, so the pipeline advances every cycle.
module flow_data_term_weights import fdt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  word_t       grad_x,
  input  word_t       grad_y,
  input  word_t       temporal_diff,
  input  word_t       grad_xx,
  input  word_t       grad_xy,
  input  word_t       grad_yy,
  input  word_t       grad_xt,
  input  word_t       grad_yt,
  input  logic        valid_req,
  input  word_t       du,
  input  word_t       dv,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output word_t       add_a00,
  output word_t       add_a01,
  output word_t       add_a11,
  output word_t       add_b0,
  output word_t       add_b1
);

  localparam int LM = MUL_LAT;
  localparam int LD = div_lat(FRAC_BITS);
  localparam int LS = SQRT_LAT;
  localparam int T_A   = LM + 1;
  localparam int T_RR  = T_A + LM;
  localparam int T_Q   = T_RR + LD;
  localparam int T_ARG = T_Q + 1;
  localparam int T_S   = T_ARG + LS;
  localparam int T_W1  = T_S + LD;
  localparam int T_W   = T_W1 + LD;
  localparam int T_OUT = pipe_lat(FRAC_BITS);

  localparam fix_t NORM = fix_t'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam fix_t EPS  = 64'sd1;

  logic [30:0] bright_wt, grad_wt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_wt <= 31'd327680;
      grad_wt   <= 31'd655360;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELTA: bright_wt <= cfg_data[30:0];
        REG_GAMMA: grad_wt   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Sign-extended operands.
  fix_t ix, iy, xx, xy, yy, fdu, fdv;
  assign ix  = fix_t'(grad_x);
  assign iy  = fix_t'(grad_y);
  assign xx  = fix_t'(grad_xx);
  assign xy  = fix_t'(grad_xy);
  assign yy  = fix_t'(grad_yy);
  assign fdu = fix_t'(du);
  assign fdv = fix_t'(dv);

  // First products of the derivatives.
  fix_t p_xx, p_yy, p_xdu, p_ydv, p_2xx, p_2xy, p_2yy, p_xxdu, p_xydv, p_xydu, p_yydv;
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m0  (.clk, .a(ix), .b(ix),  .p(p_xx));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m1  (.clk, .a(iy), .b(iy),  .p(p_yy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m2  (.clk, .a(ix), .b(fdu), .p(p_xdu));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m3  (.clk, .a(iy), .b(fdv), .p(p_ydv));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m4  (.clk, .a(xx), .b(xx),  .p(p_2xx));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m5  (.clk, .a(xy), .b(xy),  .p(p_2xy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m6  (.clk, .a(yy), .b(yy),  .p(p_2yy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m7  (.clk, .a(xx), .b(fdu), .p(p_xxdu));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m8  (.clk, .a(xy), .b(fdv), .p(p_xydv));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m9  (.clk, .a(xy), .b(fdu), .p(p_xydu));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m10 (.clk, .a(yy), .b(fdv), .p(p_yydv));

  // Temporal terms aligned with the first products.
  logic [95:0] tm;
  fdt_delay #(.W(96), .DEPTH(LM)) u_dt (.clk, .rst, .d({temporal_diff, grad_xt, grad_yt}),
                                        .q(tm));

  // Normalizers and residuals.
  fix_t n, r, n0, n1, t0, t1;
  always_ff @(posedge clk) begin
    n  <= sadd(sadd(p_xx, p_yy), NORM);
    r  <= sadd(sadd(fix_t'($signed(tm[95:64])), p_xdu), p_ydv);
    n0 <= sadd(sadd(p_2xx, p_2xy), NORM);
    n1 <= sadd(sadd(p_2yy, p_2xy), NORM);
    t0 <= sadd(sadd(fix_t'($signed(tm[63:32])), p_xxdu), p_xydv);
    t1 <= sadd(sadd(fix_t'($signed(tm[31:0])), p_xydu), p_yydv);
  end

  // Normalizer copies for the first and last divisions.
  logic [191:0] nq, nw;
  fdt_delay #(.W(192), .DEPTH(LM)) u_dn1 (.clk, .rst, .d({n, n0, n1}), .q(nq));
  fdt_delay #(.W(192), .DEPTH(T_W1 - T_A)) u_dn2 (.clk, .rst, .d({n, n0, n1}), .q(nw));

  // Squared residuals over their normalizers.
  fix_t rr, tt0, tt1, q, q0, q1;
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m11 (.clk, .a(r),  .b(r),  .p(rr));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m12 (.clk, .a(t0), .b(t0), .p(tt0));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m13 (.clk, .a(t1), .b(t1), .p(tt1));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d0 (.clk, .a(rr),  .d(fix_t'(nq[191:128])), .res(q));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d1 (.clk, .a(tt0), .d(fix_t'(nq[127:64])),  .res(q0));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d2 (.clk, .a(tt1), .d(fix_t'(nq[63:0])),    .res(q1));

  // Root arguments.
  fix_t arg, arg2, s, s2;
  always_ff @(posedge clk) begin
    arg  <= sadd(q, EPS);
    arg2 <= sadd(sadd(q0, q1), EPS);
  end

  fdt_sqrt #(.FRAC_BITS(FRAC_BITS)) u_s0 (.clk, .x(arg),  .y(s));
  fdt_sqrt #(.FRAC_BITS(FRAC_BITS)) u_s1 (.clk, .x(arg2), .y(s2));

  // Weights, zero for a sample outside the image.
  logic v_s;
  fix_t dsel, gsel, w1, g, w, w0, wg1;
  fdt_delay #(.W(1), .DEPTH(T_S)) u_dv (.clk, .rst, .d(valid_req), .q(v_s));
  assign dsel = v_s ? fix_t'({33'd0, bright_wt}) : '0;
  assign gsel = v_s ? fix_t'({33'd0, grad_wt}) : '0;

  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d3 (.clk, .a(dsel), .d(s),  .res(w1));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d4 (.clk, .a(gsel), .d(s2), .res(g));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d5 (.clk, .a(w1), .d(fix_t'(nw[191:128])), .res(w));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d6 (.clk, .a(g),  .d(fix_t'(nw[127:64])),  .res(w0));
  fdt_div #(.FRAC_BITS(FRAC_BITS)) u_d7 (.clk, .a(g),  .d(fix_t'(nw[63:0])),    .res(wg1));

  // Derivative copies for the two weighting products.
  logic [255:0] fw, fp;
  fdt_delay #(.W(256), .DEPTH(T_W)) u_df1 (.clk, .rst,
    .d({grad_x, grad_y, temporal_diff, grad_xx, grad_xy, grad_yy, grad_xt, grad_yt}), .q(fw));
  fdt_delay #(.W(256), .DEPTH(LM)) u_df2 (.clk, .rst, .d(fw), .q(fp));

  fix_t wx, wy, wt, wxx, wxy, wyy, wxt, wyt;
  fix_t px, py, pxx, pxy, pyy, pxt, pyt;
  assign wx  = fix_t'($signed(fw[255:224]));
  assign wy  = fix_t'($signed(fw[223:192]));
  assign wt  = fix_t'($signed(fw[191:160]));
  assign wxx = fix_t'($signed(fw[159:128]));
  assign wxy = fix_t'($signed(fw[127:96]));
  assign wyy = fix_t'($signed(fw[95:64]));
  assign wxt = fix_t'($signed(fw[63:32]));
  assign wyt = fix_t'($signed(fw[31:0]));
  assign px  = fix_t'($signed(fp[255:224]));
  assign py  = fix_t'($signed(fp[223:192]));
  assign pxx = fix_t'($signed(fp[159:128]));
  assign pxy = fix_t'($signed(fp[127:96]));
  assign pyy = fix_t'($signed(fp[95:64]));
  assign pxt = fix_t'($signed(fp[63:32]));
  assign pyt = fix_t'($signed(fp[31:0]));

  // Weight times first factor.
  fix_t m_wx, m_wy, m_wt, m_0xx, m_1xy, m_1yy, m_0xy;
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m14 (.clk, .a(w),   .b(wx),  .p(m_wx));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m15 (.clk, .a(w),   .b(wy),  .p(m_wy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m16 (.clk, .a(w),   .b(wt),  .p(m_wt));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m17 (.clk, .a(w0),  .b(wxx), .p(m_0xx));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m18 (.clk, .a(wg1), .b(wxy), .p(m_1xy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m19 (.clk, .a(wg1), .b(wyy), .p(m_1yy));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m20 (.clk, .a(w0),  .b(wxy), .p(m_0xy));

  // Second factor of every contribution.
  fix_t e00, e01, e11, eb0, eb1;
  fix_t g00a, g00b, g01a, g01b, g11a, g11b, gb0a, gb0b, gb1a, gb1b;
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m21 (.clk, .a(m_wx),  .b(px),  .p(e00));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m22 (.clk, .a(m_wx),  .b(py),  .p(e01));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m23 (.clk, .a(m_wy),  .b(py),  .p(e11));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m24 (.clk, .a(m_wt),  .b(px),  .p(eb0));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m25 (.clk, .a(m_wt),  .b(py),  .p(eb1));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m26 (.clk, .a(m_0xx), .b(pxx), .p(g00a));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m27 (.clk, .a(m_1xy), .b(pxy), .p(g00b));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m28 (.clk, .a(m_0xx), .b(pxy), .p(g01a));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m29 (.clk, .a(m_1xy), .b(pyy), .p(g01b));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m30 (.clk, .a(m_1yy), .b(pyy), .p(g11a));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m31 (.clk, .a(m_0xy), .b(pxy), .p(g11b));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m32 (.clk, .a(m_0xx), .b(pxt), .p(gb0a));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m33 (.clk, .a(m_1xy), .b(pyt), .p(gb0b));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m34 (.clk, .a(m_1yy), .b(pyt), .p(gb1a));
  fdt_mul #(.FRAC_BITS(FRAC_BITS)) u_m35 (.clk, .a(m_0xy), .b(pxt), .p(gb1b));

  // Gradient sums and negated right-side terms.
  fix_t c00, c01, c11, cb0, cb1, s00, s01, s11, sb0, sb1;
  always_ff @(posedge clk) begin
    c00 <= e00;
    c01 <= e01;
    c11 <= e11;
    cb0 <= -eb0;
    cb1 <= -eb1;
    s00 <= sadd(g00a, g00b);
    s01 <= sadd(g01a, g01b);
    s11 <= sadd(g11a, g11b);
    sb0 <= -sadd(gb0a, gb0b);
    sb1 <= -sadd(gb1a, gb1b);
  end

  // Result registers and strobe.
  always_ff @(posedge clk) begin
    add_a00 <= sat32(sadd(c00, s00));
    add_a01 <= sat32(sadd(c01, s01));
    add_a11 <= sat32(sadd(c11, s11));
    add_b0  <= sat32(sadd(cb0, sb0));
    add_b1  <= sat32(sadd(cb1, sb1));
  end

  fdt_delay #(.W(1), .DEPTH(T_OUT)) u_dd (.clk, .rst, .d(start), .q(done));

endmodule

[hdl/fdt_checker.sv]
// Port-level checker for flow_data_term_weights and the bind that attaches it.
// Uses fdt_pkg for the pipeline latency.
module fdt_checker import fdt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic  clk,
  input logic  rst,
  input logic  start,
  input logic  valid_req,
  input logic  done,
  input word_t add_a00,
  input word_t add_a01,
  input word_t add_a11,
  input word_t add_b0,
  input word_t add_b1
);

  localparam int LAT = pipe_lat(FRAC_BITS);

  // Every result strobe answers a transfer exactly one latency earlier.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without matching input transfer");

  // A sample outside the image gives an all-zero result.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(valid_req, LAT)) |->
      (add_a00 == 0 && add_a01 == 0 && add_a11 == 0 && add_b0 == 0 && add_b1 == 0))
    else $error("invalid sample gave a nonzero result");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind flow_data_term_weights fdt_checker #(.FRAC_BITS(FRAC_BITS)) u_fdt_checker (.*);
